### rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control store of the modular exponentiation block.
package mexp_pkg;

   localparam int DEFAULT_WORD_WIDTH = 32;
   localparam int PC_WIDTH           = 4;
   localparam int CSR_INDEX_WIDTH    = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 1'b1;

   typedef logic [PC_WIDTH-1:0] pc_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_INIT,
      ACT_MUL_ACC,
      ACT_MUL_SQ,
      ACT_WR_SQ,
      ACT_WR_ACC,
      ACT_ACC_ONE,
      ACT_ACC_ZERO,
      ACT_EMIT
   } act_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_E_ZERO,
      COND_N_ZERO,
      COND_E_BIT_CLEAR,
      COND_E_NONZERO,
      COND_MUL_PENDING
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      pc_type   target;
   } ctrl_word_type;

   typedef struct packed {
      logic e_zero;
      logic n_zero;
      logic e_lsb;
      logic mul_done;
   } status_type;

   localparam pc_type PC_IDLE         = 4'd0;
   localparam pc_type PC_CHK_EXP      = 4'd1;
   localparam pc_type PC_CHK_MOD      = 4'd2;
   localparam pc_type PC_REDUCE       = 4'd3;
   localparam pc_type PC_REDUCE_WAIT  = 4'd4;
   localparam pc_type PC_LOOP         = 4'd5;
   localparam pc_type PC_MUL_ACC      = 4'd6;
   localparam pc_type PC_MUL_ACC_WAIT = 4'd7;
   localparam pc_type PC_SQUARE       = 4'd8;
   localparam pc_type PC_SQUARE_WAIT  = 4'd9;
   localparam pc_type PC_NEXT         = 4'd10;
   localparam pc_type PC_EMIT         = 4'd11;
   localparam pc_type PC_ONE          = 4'd12;
   localparam pc_type PC_ZERO         = 4'd13;

   function automatic ctrl_word_type ucode(input pc_type pc);
      ctrl_word_type w;
      case (pc)
         PC_IDLE:         w = '{act: ACT_LOAD,     cond: COND_NO_START,    target: PC_IDLE};
         PC_CHK_EXP:      w = '{act: ACT_NONE,     cond: COND_E_ZERO,      target: PC_ONE};
         PC_CHK_MOD:      w = '{act: ACT_NONE,     cond: COND_N_ZERO,      target: PC_ZERO};
         PC_REDUCE:       w = '{act: ACT_INIT,     cond: COND_NEVER,       target: PC_IDLE};
         PC_REDUCE_WAIT:  w = '{act: ACT_WR_SQ,    cond: COND_MUL_PENDING, target: PC_REDUCE_WAIT};
         PC_LOOP:         w = '{act: ACT_NONE,     cond: COND_E_BIT_CLEAR, target: PC_SQUARE};
         PC_MUL_ACC:      w = '{act: ACT_MUL_ACC,  cond: COND_NEVER,       target: PC_IDLE};
         PC_MUL_ACC_WAIT: w = '{act: ACT_WR_ACC,   cond: COND_MUL_PENDING, target: PC_MUL_ACC_WAIT};
         PC_SQUARE:       w = '{act: ACT_MUL_SQ,   cond: COND_NEVER,       target: PC_IDLE};
         PC_SQUARE_WAIT:  w = '{act: ACT_WR_SQ,    cond: COND_MUL_PENDING, target: PC_SQUARE_WAIT};
         PC_NEXT:         w = '{act: ACT_NONE,     cond: COND_E_NONZERO,   target: PC_LOOP};
         PC_EMIT:         w = '{act: ACT_EMIT,     cond: COND_ALWAYS,      target: PC_IDLE};
         PC_ONE:          w = '{act: ACT_ACC_ONE,  cond: COND_ALWAYS,      target: PC_EMIT};
         PC_ZERO:         w = '{act: ACT_ACC_ZERO, cond: COND_ALWAYS,      target: PC_EMIT};
         default:         w = '{act: ACT_NONE,     cond: COND_ALWAYS,      target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

### rtl/mexp_mulmod.sv
`timescale 1ns / 1ps
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module mexp_mulmod
   import mexp_pkg::*;
#(
   parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WORD_WIDTH-1:0] a,
   input  logic [WORD_WIDTH-1:0] b,
   input  logic [WORD_WIDTH-1:0] n,
   output logic [WORD_WIDTH-1:0] result,
   output logic                  done
);

   localparam int CNT_WIDTH = $clog2(WORD_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(WORD_WIDTH - 1);

   function automatic logic [WORD_WIDTH-1:0] add_mod(input logic [WORD_WIDTH-1:0] x,
                                                     input logic [WORD_WIDTH-1:0] y,
                                                     input logic [WORD_WIDTH-1:0] m);
      logic [WORD_WIDTH:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WORD_WIDTH-1:0];
   endfunction

   logic [WORD_WIDTH-1:0] r_ff, r_in;
   logic [WORD_WIDTH-1:0] a_ff;
   logic [WORD_WIDTH-1:0] b_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;
   logic                  run_ff;
   logic                  done_ff;
   logic [WORD_WIDTH-1:0] dbl;

   always_comb begin
      dbl  = add_mod(r_ff, r_ff, n);
      r_in = b_ff[WORD_WIDTH-1] ? add_mod(dbl, a_ff, n) : dbl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff <= '0;
         a_ff <= a;
         b_ff <= b;
      end else if (run_ff) begin
         r_ff <= r_in;
         b_ff <= {b_ff[WORD_WIDTH-2:0], 1'b0};
      end
   end

   assign result = r_ff;
   assign done   = done_ff;

endmodule

### rtl/mexp_datapath.sv
`timescale 1ns / 1ps
// Operand registers, configuration registers and result register of the exponentiator.
module mexp_datapath
   import mexp_pkg::*;
#(
   parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_wdata,
   input  logic [WORD_WIDTH-1:0]      req_base,
   input  act_type                    act,
   output status_type                 status,
   output logic                       rsp_valid,
   output logic [WORD_WIDTH-1:0]      rsp_power_result
);

   logic [WORD_WIDTH-1:0] exp_ff;
   logic [WORD_WIDTH-1:0] mod_ff;
   logic [WORD_WIDTH-1:0] e_ff, e_in;
   logic [WORD_WIDTH-1:0] n_ff, n_in;
   logic [WORD_WIDTH-1:0] sq_ff, sq_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_data_ff;
   logic [WORD_WIDTH-1:0] one_mod_n;
   logic                  mul_start;
   logic [WORD_WIDTH-1:0] mul_a, mul_b, mul_result;
   logic                  mul_done;

   assign one_mod_n = (n_ff == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);

   always_comb begin
      e_in      = e_ff;
      n_in      = n_ff;
      sq_in     = sq_ff;
      acc_in    = acc_ff;
      mul_start = 1'b0;
      mul_a     = sq_ff;
      mul_b     = sq_ff;
      case (act)
         ACT_LOAD: begin
            e_in  = exp_ff;
            n_in  = mod_ff;
            sq_in = req_base;
         end
         ACT_INIT: begin
            acc_in    = one_mod_n;
            mul_start = 1'b1;
            mul_a     = one_mod_n;
         end
         ACT_MUL_ACC: begin
            mul_start = 1'b1;
            mul_b     = acc_ff;
         end
         ACT_MUL_SQ: begin
            mul_start = 1'b1;
            e_in      = e_ff >> 1;
         end
         ACT_WR_SQ: begin
            if (mul_done) begin
               sq_in = mul_result;
            end
         end
         ACT_WR_ACC: begin
            if (mul_done) begin
               acc_in = mul_result;
            end
         end
         ACT_ACC_ONE:  acc_in = WORD_WIDTH'(1);
         ACT_ACC_ZERO: acc_in = '0;
         default: ;
      endcase
      rsp_valid_in = (act == ACT_EMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff       <= WORD_WIDTH'(1);
         mod_ff       <= WORD_WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_EXPONENT: exp_ff <= csr_wdata;
               CSR_MODULUS:  mod_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      e_ff   <= e_in;
      n_ff   <= n_in;
      sq_ff  <= sq_in;
      acc_ff <= acc_in;
      if (rsp_valid_in) begin
         rsp_data_ff <= acc_ff;
      end
   end

   mexp_mulmod #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .n      (n_ff),
      .result (mul_result),
      .done   (mul_done)
   );

   assign status.e_zero   = (e_ff == '0);
   assign status.n_zero   = (n_ff == '0);
   assign status.e_lsb    = e_ff[0];
   assign status.mul_done = mul_done;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

endmodule

### rtl/mexp_sequencer.sv
`timescale 1ns / 1ps
// Step counter and control store walk with conditional jumps.
module mexp_sequencer
   import mexp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  status_type    status,
   output ctrl_word_type ctrl,
   output logic          busy
);

   pc_type pc_ff, pc_in;
   logic   take;

   assign ctrl = ucode(pc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:       take = 1'b0;
         COND_ALWAYS:      take = 1'b1;
         COND_NO_START:    take = !start;
         COND_E_ZERO:      take = status.e_zero;
         COND_N_ZERO:      take = status.n_zero;
         COND_E_BIT_CLEAR: take = !status.e_lsb;
         COND_E_NONZERO:   take = !status.e_zero;
         COND_MUL_PENDING: take = !status.mul_done;
         default:          take = 1'b1;
      endcase
      pc_in = take ? ctrl.target : pc_ff + PC_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign busy = (pc_ff != PC_IDLE);

endmodule

### rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// Top level of the modular exponentiation block: sequencer plus datapath.
//
// Usage:
//   Program the exponent (index 0) and modulus (index 1) through the csr_ port while idle;
//   a write lands at the clock edge at which csr_write_en is high. Both reset to 1.
//   Raise start with req_base; the beat is taken at an edge where busy is low.
//   busy stays high until the result is produced; rsp_valid then strobes for one cycle
//   with rsp_power_result = req_base ** exponent mod modulus (1 for a zero exponent).
//   The receiver cannot stall: the result is shown once and must be captured.
// Operation:
//   Each modular product runs on the bit-serial multiplier. One product reduces the base,
//   then each exponent bit up to the top set bit costs a squaring plus a multiply when the
//   bit is set, with a bit-test step and a remaining-exponent test step per bit. A zero
//   exponent or a zero modulus skips the products, and 1 or 0 respectively is emitted.
//   busy falls in the strobe cycle, so the next beat may be taken then.
// Reset:
//   Synchronous, active high: the step counter returns to idle, no strobe is pending.
module modular_exponentiation
   import mexp_pkg::*;
#(
   parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [WORD_WIDTH-1:0]      req_base,
   output logic                       rsp_valid,
   output logic [WORD_WIDTH-1:0]      rsp_power_result,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_wdata
);

   ctrl_word_type ctrl;
   status_type    status;

   mexp_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   mexp_datapath #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_base         (req_base),
      .act              (ctrl.act),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_power_result (rsp_power_result)
   );

endmodule

### rtl/mexp_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the exponentiator handshake, bound to the top level.
module mexp_checker
   import mexp_pkg::*;
#(
   parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [WORD_WIDTH-1:0] rsp_power_result
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted beat");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_result_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_power_result))
      else $error("result beat carries unknown bits");

endmodule

bind modular_exponentiation mexp_checker #(.WORD_WIDTH(WORD_WIDTH)) u_mexp_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the modular exponentiation block: directed and random bases.
module tb;
   import mexp_pkg::*;

   localparam int W          = DEFAULT_WORD_WIDTH;
   localparam int LIMIT      = 3_000_000;
   localparam int TAIL       = 2400;
   localparam int PHASES     = 10;
   localparam int PHASE_LEN  = 29;

   typedef struct {
      logic                       is_write;
      logic [CSR_INDEX_WIDTH-1:0] idx;
      logic [W-1:0]               data;
      logic                       calm;
   } beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [W-1:0]               req_base = '0;
   logic                       rsp_valid;
   logic [W-1:0]               rsp_power_result;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_EXPONENT;
   logic [W-1:0]               csr_wdata = '0;

   beat_type     stimulus_q[$];
   logic [W-1:0] power_q[$];
   logic [W-1:0] exp_shadow = 1;
   logic [W-1:0] mod_shadow = 1;
   int           hold_off = 0;
   int           errors = 0;
   int           cycle_count = 0;
   logic         next_start, next_we;
   beat_type     head;

   modular_exponentiation #(.WORD_WIDTH(W)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_base         (req_base),
      .rsp_valid        (rsp_valid),
      .rsp_power_result (rsp_power_result),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [W-1:0] power_mod(logic [W-1:0] b, logic [W-1:0] e,
                                              logic [W-1:0] n);
      logic [2*W-1:0] sq, acc, n_wide;
      logic [W-1:0]   bits;
      if (e == '0) return W'(1);
      if (n == '0) return '0;
      n_wide = (2*W)'(n);
      sq     = (2*W)'(b) % n_wide;
      acc    = (2*W)'(1);
      acc    = acc % n_wide;
      bits   = e;
      while (bits != '0) begin
         if (bits[0]) acc = (acc * sq) % n_wide;
         sq   = (sq * sq) % n_wide;
         bits = bits >> 1;
      end
      return acc[W-1:0];
   endfunction

   task automatic log_mismatch(string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   task automatic add_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [W-1:0] value);
      stimulus_q.push_back('{is_write: 1'b1, idx: idx, data: value, calm: 1'b0});
   endtask

   task automatic add_base(logic [W-1:0] value, logic calm);
      stimulus_q.push_back('{is_write: 1'b0, idx: CSR_EXPONENT, data: value, calm: calm});
   endtask

   // driver: hold a beat until taken, write registers only once the block has drained
   always @(posedge clock) begin
      if (reset) begin
         start        <= 1'b0;
         req_base     <= '0;
         csr_write_en <= 1'b0;
         csr_index    <= CSR_EXPONENT;
         csr_wdata    <= '0;
         hold_off     <= 0;
         exp_shadow   <= 1;
         mod_shadow   <= 1;
      end else begin
         next_start = start;
         next_we    = 1'b0;
         if (start && !busy) begin
            power_q.push_back(power_mod(req_base, exp_shadow, mod_shadow));
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (hold_off != 0) begin
               hold_off <= hold_off - 1;
            end else if (stimulus_q.size() != 0) begin
               head = stimulus_q[0];
               if (head.is_write) begin
                  if (!start && !busy && !rsp_valid && power_q.size() == 0) begin
                     next_we = 1'b1;
                     csr_index <= head.idx;
                     csr_wdata <= head.data;
                     if (head.idx == CSR_EXPONENT) exp_shadow <= head.data;
                     else mod_shadow <= head.data;
                     void'(stimulus_q.pop_front());
                  end
               end else if (!head.calm && $urandom_range(0, 3) == 0) begin
                  hold_off <= $urandom_range(0, 15);
               end else begin
                  next_start = 1'b1;
                  req_base <= head.data;
                  void'(stimulus_q.pop_front());
               end
            end
         end
         start        <= next_start;
         csr_write_en <= next_we;
      end
   end

   // monitor: every strobe must match the oldest predicted power
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (power_q.size() == 0) begin
            log_mismatch($sformatf("unexpected result %h", rsp_power_result));
         end else if (rsp_power_result !== power_q[0]) begin
            log_mismatch($sformatf("power_result got %h, wanted %h",
                                   rsp_power_result, power_q[0]));
            void'(power_q.pop_front());
         end else begin
            void'(power_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [W-1:0] e, n, b;
      int           pick;

      // registers still at their reset values
      add_base('0, 1'b0);
      add_base('1, 1'b0);
      add_write(CSR_EXPONENT, '0);
      add_base(32'd5, 1'b0);
      add_write(CSR_MODULUS, '0);
      add_base(32'd7, 1'b0);
      add_write(CSR_EXPONENT, 32'd3);
      add_base(32'd9, 1'b0);
      add_write(CSR_EXPONENT, 32'd65537);
      add_write(CSR_MODULUS, 32'hFFFF_FFFF);
      add_base('0, 1'b0);
      add_base(32'd1, 1'b0);
      add_base(32'hFFFF_FFFF, 1'b0);
      add_base(32'hFFFF_FFFE, 1'b0);
      add_base(32'h8000_0000, 1'b0);
      add_write(CSR_EXPONENT, 32'hFFFF_FFFF);
      add_write(CSR_MODULUS, 32'hFFFF_FFFB);
      add_base(32'd2, 1'b0);
      add_base(32'hFFFF_FFFF, 1'b0);
      add_base(32'h1234_5678, 1'b0);
      add_write(CSR_EXPONENT, 32'd2);
      add_write(CSR_MODULUS, 32'd1000);
      add_base(32'd999_999, 1'b0);
      add_base(32'd1000, 1'b0);
      add_write(CSR_EXPONENT, 32'h8000_0000);
      add_write(CSR_MODULUS, 32'h8000_0001);
      add_base(32'd3, 1'b0);

      for (int k = 0; k < PHASES; k++) begin
         case (k)
            0:       begin e = $urandom; n = $urandom | 32'h8000_0000; end
            1:       begin e = $urandom_range(1, 255); n = $urandom_range(2, 1000); end
            2:       begin e = 32'd65537; n = $urandom; end
            3:       begin e = '0; n = $urandom; end
            4:       begin e = 32'hFFFF_FFFF; n = $urandom_range(2, 65535); end
            5:       begin e = $urandom_range(1, 65535); n = 32'd1; end
            6:       begin e = $urandom; n = 32'hFFFF_FFFF; end
            7:       begin e = 32'd3; n = $urandom; end
            8:       begin e = $urandom; n = '0; end
            default: begin e = $urandom_range(1, 15); n = $urandom; end
         endcase
         add_write(CSR_EXPONENT, e);
         add_write(CSR_MODULUS, n);
         for (int i = 0; i < PHASE_LEN; i++) begin
            pick = $urandom_range(0, 3);
            if (pick == 2 && n != '0) begin
               b = $urandom % n;
            end else if (pick == 3) begin
               case ($urandom_range(0, 3))
                  0:       b = '0;
                  1:       b = 32'd1;
                  2:       b = n - 1;
                  default: b = n;
               endcase
            end else begin
               b = $urandom;
            end
            add_base(b, k == PHASES - 1);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (stimulus_q.size() != 0 || power_q.size() != 0 || start) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (power_q.size() != 0) begin
         log_mismatch($sformatf("%0d results never arrived", power_q.size()));
      end
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
